// ----- hw/rtl/sdspi_pkg.sv -----
package sdspi_pkg;

    localparam int BlockBytes = 512;
    localparam int WakeBytes  = 10;
    localparam int CntW       = 10;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'd0,
        PH_WAKE  = 6'd1,
        PH_TOKEN = 6'd2,
        PH_DATA  = 6'd3,
        PH_CRC   = 6'd4,
        PH_CMD   = 6'd8
    } t_phase_base;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_READ  = 2'd1,
        ACT_BYTE  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_RESP  = 2'd0,
        CFG_RETRY = 2'd1,
        CFG_TOKEN = 2'd2,
        CFG_NONE  = 2'd3
    } t_cfg_idx;

    localparam logic [2:0] ST_CMD0 = 3'd0;
    localparam logic [2:0] ST_CMD8 = 3'd1;
    localparam logic [2:0] ST_OCR1 = 3'd2;
    localparam logic [2:0] ST_APP  = 3'd3;
    localparam logic [2:0] ST_OP   = 3'd4;
    localparam logic [2:0] ST_OCR2 = 3'd5;
    localparam logic [2:0] ST_BLEN = 3'd6;
    localparam logic [2:0] ST_READ = 3'd7;

    localparam logic [1:0] SUB_SEND  = 2'd0;
    localparam logic [1:0] SUB_WAIT  = 2'd1;
    localparam logic [1:0] SUB_MORE  = 2'd2;
    localparam logic [1:0] SUB_TRAIL = 2'd3;

    localparam logic [3:0] S_OK      = 4'd0;
    localparam logic [3:0] S_RESP_TO = 4'd1;
    localparam logic [3:0] S_SPI     = 4'd2;
    localparam logic [3:0] S_BAD_R1  = 4'd3;
    localparam logic [3:0] S_BAD_C8  = 4'd4;
    localparam logic [3:0] S_VOLT    = 4'd5;
    localparam logic [3:0] S_RDY_TO  = 4'd6;
    localparam logic [3:0] S_BAD_OCR = 4'd7;
    localparam logic [3:0] S_TOK_TO  = 4'd8;
    localparam logic [3:0] S_ERR_TOK = 4'd9;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       select_low;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       done_res;
        logic [3:0] status;
        logic       high_capacity;
    } t_result;

endpackage

// ----- hw/rtl/sd_spi_init_and_block_read.sv -----
// result: registered; it appears in the cycle after the request is taken
// throughput: one request per cycle while the result is not stalled; the result register is refilled whenever it is
// empty or taken in the same cycle
// reset: synchronous, active low; returns to idle with the limits at their maxima
module sd_spi_init_and_block_read (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_sector,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_error,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_select_low,
    output logic        o_data_valid,
    output logic [7:0]  o_data_byte,
    output logic        o_done_res,
    output logic [3:0]  o_status,
    output logic        o_high_capacity,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sdspi_pkg::*;

    logic [7:0]  r_resp_lim, r_retry_lim;
    logic [15:0] r_tok_lim;
    logic [5:0]  r_phase, n_phase;
    logic [CntW-1:0] r_bcnt, n_bcnt;
    logic [15:0] r_wcnt, n_wcnt;
    logic [7:0]  r_retry, n_retry;
    logic [5:0]  r_cidx, n_cidx;
    logic [31:0] r_carg, n_carg;
    logic [7:0]  r_resp [5];
    logic [7:0]  n_resp [5];
    logic        r_v1, n_v1, r_hc, n_hc;
    logic        r_ovalid;
    t_result     r_res, n_res;
    logic        take;

    logic [7:0]  rsp_lim, rty_lim;
    logic [15:0] tok_lim;
    logic [2:0]  step;
    logic [1:0]  sub;
    logic [7:0]  rx;

    assign o_stall     = r_ovalid & i_stall;
    assign take        = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;
    assign rsp_lim = (r_resp_lim == 8'd0) ? 8'd1 : r_resp_lim;
    assign rty_lim = (r_retry_lim == 8'd0) ? 8'd1 : r_retry_lim;
    assign tok_lim = (r_tok_lim == 16'd0) ? 16'd1 : r_tok_lim;
    assign step = 3'((r_phase - 6'(PH_CMD)) >> 2);
    assign sub  = 2'(r_phase - 6'(PH_CMD));
    assign rx   = i_rx_byte;

    function automatic logic [7:0] frame(input logic [2:0] k, input logic [5:0] ci,
                                         input logic [31:0] ca);
        logic [7:0] b;
        unique case (k)
            3'd0: b = {2'b01, ci};
            3'd1: b = ca[31:24];
            3'd2: b = ca[23:16];
            3'd3: b = ca[15:8];
            3'd4: b = ca[7:0];
            default: b = (ci == 6'd0) ? 8'h95 : (ci == 6'd8) ? 8'h87 : 8'h01;
        endcase
        return b;
    endfunction

    always_comb begin
        n_phase = r_phase; n_bcnt = r_bcnt; n_wcnt = r_wcnt; n_retry = r_retry;
        n_cidx = r_cidx; n_carg = r_carg; n_v1 = r_v1; n_hc = r_hc;
        for (int i = 0; i < 5; i++) n_resp[i] = r_resp[i];
        n_res = '0;
        // state holds and result fields stay zero unless a branch below sets them
        if (i_action == ACT_START && r_phase == PH_IDLE) begin
            n_v1 = 1'b0; n_hc = 1'b0; n_phase = PH_WAKE; n_bcnt = '0;
            n_res.tx_valid = 1'b1; n_res.tx_byte = 8'hFF;
        end else if (i_action == ACT_READ && r_phase == PH_IDLE) begin
            n_cidx = 6'd17; n_carg = i_sector; n_phase = 6'(PH_CMD) + {1'b0, ST_READ, 2'b00};
            n_bcnt = '0; n_res.tx_valid = 1'b1; n_res.select_low = 1'b1;
            n_res.tx_byte = {2'b01, 6'd17};
        end else if (i_action == ACT_BYTE && r_phase != PH_IDLE) begin
            if (i_rx_error) begin
                n_res.done_res = 1'b1; n_res.status = S_SPI; n_phase = PH_IDLE;
            end else if (r_phase == PH_WAKE) begin
                n_bcnt = r_bcnt + 1'b1;
                if (n_bcnt < CntW'(WakeBytes)) begin
                    n_res.tx_valid = 1'b1; n_res.tx_byte = 8'hFF;
                end else begin
                    n_cidx = 6'd0; n_carg = '0; n_phase = PH_CMD; n_bcnt = '0;
                    n_res.tx_valid = 1'b1; n_res.select_low = 1'b1; n_res.tx_byte = 8'h40;
                end
            end else if (r_phase == PH_TOKEN) begin
                n_res.tx_valid = 1'b1; n_res.select_low = 1'b1; n_res.tx_byte = 8'hFF;
                if (rx == 8'hFE) begin
                    n_phase = PH_DATA; n_bcnt = '0;
                end else if (rx == 8'hFF) begin
                    n_wcnt = r_wcnt + 1'b1;
                    if (n_wcnt >= tok_lim) begin
                        n_res = '0; n_res.done_res = 1'b1; n_res.status = S_TOK_TO;
                        n_phase = PH_IDLE;
                    end
                end else begin
                    n_res = '0; n_res.done_res = 1'b1; n_res.status = S_ERR_TOK;
                    n_phase = PH_IDLE;
                end
            end else if (r_phase == PH_DATA) begin
                n_res.data_valid = 1'b1; n_res.data_byte = rx;
                n_res.tx_valid = 1'b1; n_res.select_low = 1'b1; n_res.tx_byte = 8'hFF;
                if (r_bcnt >= CntW'(BlockBytes - 1)) begin
                    n_phase = PH_CRC; n_bcnt = '0;
                end else n_bcnt = r_bcnt + 1'b1;
            end else if (r_phase == PH_CRC) begin
                n_bcnt = r_bcnt + 1'b1;
                if (n_bcnt >= CntW'(2)) begin
                    n_res.done_res = 1'b1; n_res.status = S_OK; n_phase = PH_IDLE;
                end else begin
                    n_res.tx_valid = 1'b1; n_res.select_low = 1'b1; n_res.tx_byte = 8'hFF;
                end
            end else if (r_phase < PH_CMD || r_phase >= 6'(PH_CMD) + 6'd32) begin
                n_phase = PH_IDLE;
            end else begin
                unique case (sub)
                    SUB_SEND: begin
                        n_bcnt = r_bcnt + 1'b1;
                        n_res.tx_valid = 1'b1; n_res.select_low = 1'b1;
                        if (n_bcnt < CntW'(6)) begin
                            n_res.tx_byte = frame(n_bcnt[2:0], r_cidx, r_carg);
                        end else begin
                            n_phase = r_phase + 6'd1; n_wcnt = '0; n_res.tx_byte = 8'hFF;
                        end
                    end
                    SUB_WAIT: begin
                        if (rx == 8'hFF) begin
                            n_wcnt = r_wcnt + 1'b1;
                            if (n_wcnt >= {8'd0, rsp_lim}) begin
                                n_res.done_res = 1'b1; n_res.status = S_RESP_TO;
                                n_phase = PH_IDLE;
                            end else begin
                                n_res.tx_valid = 1'b1; n_res.select_low = 1'b1;
                                n_res.tx_byte = 8'hFF;
                            end
                        end else if (!(rx == 8'h00 || rx == 8'h01 ||
                                       (step == ST_CMD8 && rx == 8'h05))) begin
                            n_res.done_res = 1'b1; n_res.status = S_BAD_R1; n_phase = PH_IDLE;
                        end else begin
                            n_resp[0] = rx;
                            if (step == ST_READ) begin
                                if (rx != 8'h00) begin
                                    n_res.done_res = 1'b1; n_res.status = S_BAD_R1;
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_phase = PH_TOKEN; n_wcnt = '0;
                                    n_res.tx_valid = 1'b1; n_res.select_low = 1'b1;
                                    n_res.tx_byte = 8'hFF;
                                end
                            end else begin
                                if ((step == ST_CMD8 && rx != 8'h05) || step == ST_OCR1 ||
                                    step == ST_OCR2) begin
                                    n_phase = r_phase + 6'd1; n_bcnt = CntW'(1);
                                end else n_phase = r_phase + 6'd2;
                                n_res.tx_valid = 1'b1; n_res.select_low = 1'b1;
                                n_res.tx_byte = 8'hFF;
                            end
                        end
                    end
                    SUB_MORE: begin
                        n_resp[(r_bcnt < CntW'(5)) ? 3'(r_bcnt) : 3'd4] = rx;
                        n_bcnt = r_bcnt + 1'b1;
                        if (n_bcnt >= CntW'(5)) n_phase = r_phase + 6'd1;
                        n_res.tx_valid = 1'b1; n_res.select_low = 1'b1; n_res.tx_byte = 8'hFF;
                    end
                    default: begin
                        // evaluate the stored response and pick the next command or end the operation
                        logic       nxt;
                        logic [2:0] ns;
                        logic [5:0] ni;
                        logic [31:0] na;
                        nxt = 1'b0; ns = ST_CMD0; ni = '0; na = '0;
                        unique case (step)
                            ST_CMD0: if (r_resp[0] != 8'h01) begin
                                n_res.done_res = 1'b1; n_res.status = S_BAD_R1;
                            end else begin
                                nxt = 1'b1; ns = ST_CMD8; ni = 6'd8; na = 32'h000001AA;
                            end
                            ST_CMD8: begin
                                if (r_resp[0] == 8'h01 && r_resp[1] == 8'h00 &&
                                    r_resp[2] == 8'h00 && r_resp[3] == 8'h01 &&
                                    r_resp[4] == 8'hAA) begin
                                    n_v1 = 1'b0; nxt = 1'b1;
                                end else if (r_resp[0] == 8'h05) begin
                                    n_v1 = 1'b1; nxt = 1'b1;
                                end else begin
                                    n_res.done_res = 1'b1; n_res.status = S_BAD_C8;
                                end
                                ns = ST_OCR1; ni = 6'd58;
                            end
                            ST_OCR1: if (r_resp[0] != 8'h01) begin
                                n_res.done_res = 1'b1; n_res.status = S_BAD_R1;
                            end else if ((r_resp[2] & 8'h3C) != 8'h3C) begin
                                n_res.done_res = 1'b1; n_res.status = S_VOLT;
                            end else begin
                                n_retry = '0; nxt = 1'b1; ns = ST_APP; ni = 6'd55;
                            end
                            ST_APP: if (r_resp[0] != 8'h01) begin
                                n_res.done_res = 1'b1; n_res.status = S_BAD_R1;
                            end else begin
                                nxt = 1'b1; ns = ST_OP; ni = 6'd41;
                                na = r_v1 ? 32'd0 : 32'h40000000;
                            end
                            ST_OP: if (r_resp[0] == 8'h00) begin
                                nxt = 1'b1;
                                if (r_v1) begin
                                    ns = ST_BLEN; ni = 6'd16; na = 32'(BlockBytes);
                                end else begin
                                    ns = ST_OCR2; ni = 6'd58;
                                end
                            end else if (r_resp[0] == 8'h01) begin
                                if (r_retry != 8'hFF) n_retry = r_retry + 8'd1;
                                if (n_retry >= rty_lim) begin
                                    n_res.done_res = 1'b1; n_res.status = S_RDY_TO;
                                end else begin
                                    nxt = 1'b1; ns = ST_APP; ni = 6'd55;
                                end
                            end else begin
                                n_res.done_res = 1'b1; n_res.status = S_BAD_R1;
                            end
                            ST_OCR2: if ((r_resp[1] & 8'hC0) == 8'hC0) begin
                                n_hc = 1'b1; n_res.done_res = 1'b1; n_res.status = S_OK;
                            end else if ((r_resp[1] & 8'hC0) == 8'h80) begin
                                nxt = 1'b1; ns = ST_BLEN; ni = 6'd16; na = 32'(BlockBytes);
                            end else begin
                                n_res.done_res = 1'b1; n_res.status = S_BAD_OCR;
                            end
                            default: begin
                                n_res.done_res = 1'b1; n_res.status = S_OK;
                            end
                        endcase
                        if (nxt) begin
                            n_cidx = ni; n_carg = na; n_bcnt = '0;
                            n_phase = 6'(PH_CMD) + {1'b0, ns, 2'b00};
                            n_res.tx_valid = 1'b1; n_res.select_low = 1'b1;
                            n_res.tx_byte = {2'b01, ni};
                        end else n_phase = PH_IDLE;
                    end
                endcase
            end
        end
        n_res.high_capacity = n_hc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_lim <= 8'hFF; r_retry_lim <= 8'hFF; r_tok_lim <= 16'hFFFF;
            r_phase <= PH_IDLE; r_bcnt <= '0; r_wcnt <= '0; r_retry <= '0;
            r_cidx <= '0; r_carg <= '0; r_v1 <= 1'b0; r_hc <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_RESP:  r_resp_lim  <= i_cfg_data[7:0];
                    CFG_RETRY: r_retry_lim <= i_cfg_data[7:0];
                    CFG_TOKEN: r_tok_lim   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (take) begin
                r_phase <= n_phase; r_bcnt <= n_bcnt; r_wcnt <= n_wcnt;
                r_retry <= n_retry; r_cidx <= n_cidx; r_carg <= n_carg;
                r_v1 <= n_v1; r_hc <= n_hc;
            end
            if (take) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
            for (int i = 0; i < 5; i++) r_resp[i] <= n_resp[i];
        end
    end

    assign o_valid         = r_ovalid;
    assign o_tx_valid      = r_res.tx_valid;
    assign o_tx_byte       = r_res.tx_byte;
    assign o_select_low    = r_res.select_low;
    assign o_data_valid    = r_res.data_valid;
    assign o_data_byte     = r_res.data_byte;
    assign o_done_res      = r_res.done_res;
    assign o_status        = r_res.status;
    assign o_high_capacity = r_res.high_capacity;
endmodule

// ----- hw/rtl/sdspi_checker.sv -----
module sdspi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_tx_valid,
    input logic       o_data_valid,
    input logic       o_done_res,
    input logic [3:0] o_status
);
    import sdspi_pkg::*;

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid && i_stall |=> o_valid;
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped while stalled");

    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_tx_valid && !o_data_valid)
        else $error("done with exchange request");

    a_data_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data_valid |-> o_tx_valid)
        else $error("data byte without next exchange");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_status == S_OK)
        else $error("status without done");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("request produced no result");
endmodule

bind sd_spi_init_and_block_read sdspi_checker u_sdspi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_tx_valid(o_tx_valid),
    .o_data_valid(o_data_valid), .o_done_res(o_done_res), .o_status(o_status)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import sdspi_pkg::*;

    typedef struct {
        t_action     act;
        logic [31:0] sector;
        logic [7:0]  rx;
        logic        err;
    } req_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_action = ACT_NONE;
    logic [31:0] i_sector = '0;
    logic [7:0]  i_rx_byte = '0;
    logic        i_rx_error = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_select_low;
    logic        o_data_valid;
    logic [7:0]  o_data_byte;
    logic        o_done_res;
    logic [3:0]  o_status;
    logic        o_high_capacity;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_NONE;
    logic [15:0] i_cfg_data = '0;

    sd_spi_init_and_block_read i_dut (.*);

    // controller model state
    logic [7:0]  lim_resp = 8'd255;
    logic [7:0]  lim_retry = 8'd255;
    logic [15:0] lim_token = 16'hFFFF;
    logic [5:0]  ph = PH_IDLE;
    logic [9:0]  cnt = '0;
    logic [15:0] wait_cnt = '0;
    logic [7:0]  retry_cnt = '0;
    logic [5:0]  cmd_idx = '0;
    logic [31:0] cmd_arg = '0;
    logic [7:0]  resp [5] = '{default: 8'h00};
    logic        is_v1 = 1'b0;
    logic        is_hc = 1'b0;
    t_result     nxt;

    req_t    req_q[$];
    t_result exp_q[$];
    int      errors = 0;
    int      queued = 0;
    bit      noise_on = 1'b0;
    bit      full_read_done = 1'b0;
    bit      calm = 1'b0;
    bit      in_taken = 1'b0;
    int      gap = 0;
    int      stall_cnt = 0;

    initial forever #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic logic [7:0] frame_byte(int k);
        if (k == 0) return 8'h40 | {2'b00, cmd_idx};
        if (k <= 4) return 8'(cmd_arg >> (8 * (4 - k)));
        if (cmd_idx == 6'd0) return 8'h95;
        if (cmd_idx == 6'd8) return 8'h87;
        return 8'h01;
    endfunction

    function automatic void emit(logic sel, logic [7:0] b);
        nxt.tx_valid = 1'b1;
        nxt.tx_byte = b;
        nxt.select_low = sel;
    endfunction

    function automatic void finish_op(logic [3:0] st);
        nxt.done_res = 1'b1;
        nxt.status = st;
        ph = PH_IDLE;
    endfunction

    function automatic void begin_cmd(logic [2:0] stp, logic [5:0] idx, logic [31:0] arg);
        cmd_idx = idx;
        cmd_arg = arg;
        ph = 6'(PH_CMD) + {1'b0, stp, 2'b00};
        cnt = '0;
        emit(1'b1, frame_byte(0));
    endfunction

    function automatic void evaluate(logic [2:0] stp);
        case (stp)
            ST_CMD0: begin
                if (resp[0] != 8'h01) finish_op(S_BAD_R1);
                else begin_cmd(ST_CMD8, 6'd8, 32'h0000_01AA);
            end
            ST_CMD8: begin
                if (resp[0] == 8'h01 && resp[1] == 8'h00 && resp[2] == 8'h00 &&
                    resp[3] == 8'h01 && resp[4] == 8'hAA) begin
                    is_v1 = 1'b0;
                    begin_cmd(ST_OCR1, 6'd58, 32'd0);
                end else if (resp[0] == 8'h05) begin
                    is_v1 = 1'b1;
                    begin_cmd(ST_OCR1, 6'd58, 32'd0);
                end else finish_op(S_BAD_C8);
            end
            ST_OCR1: begin
                if (resp[0] != 8'h01) finish_op(S_BAD_R1);
                else if ((resp[2] & 8'h3C) != 8'h3C) finish_op(S_VOLT);
                else begin
                    retry_cnt = '0;
                    begin_cmd(ST_APP, 6'd55, 32'd0);
                end
            end
            ST_APP: begin
                if (resp[0] != 8'h01) finish_op(S_BAD_R1);
                else begin_cmd(ST_OP, 6'd41, is_v1 ? 32'd0 : 32'h4000_0000);
            end
            ST_OP: begin
                if (resp[0] == 8'h00) begin
                    if (is_v1) begin_cmd(ST_BLEN, 6'd16, 32'(BlockBytes));
                    else begin_cmd(ST_OCR2, 6'd58, 32'd0);
                end else if (resp[0] == 8'h01) begin
                    if (retry_cnt < 8'd255) retry_cnt++;
                    if (retry_cnt >= lim_retry) finish_op(S_RDY_TO);
                    else begin_cmd(ST_APP, 6'd55, 32'd0);
                end else finish_op(S_BAD_R1);
            end
            ST_OCR2: begin
                if ((resp[1] & 8'hC0) == 8'hC0) begin
                    is_hc = 1'b1;
                    finish_op(S_OK);
                end else if ((resp[1] & 8'hC0) == 8'h80) begin
                    begin_cmd(ST_BLEN, 6'd16, 32'(BlockBytes));
                end else finish_op(S_BAD_OCR);
            end
            default: finish_op(S_OK);
        endcase
    endfunction

    function automatic void card_byte(logic [7:0] rx);
        logic [2:0] stp;
        logic [1:0] sub;
        if (ph == PH_WAKE) begin
            cnt++;
            if (cnt < 10'(WakeBytes)) emit(1'b0, 8'hFF);
            else begin_cmd(ST_CMD0, 6'd0, 32'd0);
            return;
        end
        if (ph == PH_TOKEN) begin
            if (rx == 8'hFE) begin
                ph = PH_DATA;
                cnt = '0;
                emit(1'b1, 8'hFF);
            end else if (rx == 8'hFF) begin
                wait_cnt++;
                if (wait_cnt >= lim_token) finish_op(S_TOK_TO);
                else emit(1'b1, 8'hFF);
            end else finish_op(S_ERR_TOK);
            return;
        end
        if (ph == PH_DATA) begin
            nxt.data_valid = 1'b1;
            nxt.data_byte = rx;
            if (cnt >= 10'(BlockBytes - 1)) begin
                ph = PH_CRC;
                cnt = '0;
            end else cnt++;
            emit(1'b1, 8'hFF);
            return;
        end
        if (ph == PH_CRC) begin
            cnt++;
            if (cnt >= 10'd2) finish_op(S_OK);
            else emit(1'b1, 8'hFF);
            return;
        end
        if (ph < 6'(PH_CMD) || ph >= 6'(PH_CMD) + 6'd32) begin
            ph = PH_IDLE;
            return;
        end
        stp = 3'((ph - 6'(PH_CMD)) >> 2);
        sub = 2'(ph - 6'(PH_CMD));
        case (sub)
            SUB_SEND: begin
                cnt++;
                if (cnt < 10'd6) emit(1'b1, frame_byte(cnt));
                else begin
                    ph++;
                    wait_cnt = '0;
                    emit(1'b1, 8'hFF);
                end
            end
            SUB_WAIT: begin
                if (rx == 8'hFF) begin
                    wait_cnt++;
                    if (wait_cnt >= 16'(lim_resp)) finish_op(S_RESP_TO);
                    else emit(1'b1, 8'hFF);
                    return;
                end
                if (!(rx == 8'h00 || rx == 8'h01 || (stp == ST_CMD8 && rx == 8'h05))) begin
                    finish_op(S_BAD_R1);
                    return;
                end
                resp[0] = rx;
                if (stp == ST_READ) begin
                    if (rx != 8'h00) finish_op(S_BAD_R1);
                    else begin
                        ph = PH_TOKEN;
                        wait_cnt = '0;
                        emit(1'b1, 8'hFF);
                    end
                    return;
                end
                if ((stp == ST_CMD8 && rx != 8'h05) || stp == ST_OCR1 || stp == ST_OCR2) begin
                    ph++;
                    cnt = 10'd1;
                end else ph = ph + 6'd2;
                emit(1'b1, 8'hFF);
            end
            SUB_MORE: begin
                resp[(cnt < 10'd5) ? 3'(cnt) : 3'd4] = rx;
                cnt++;
                if (cnt >= 10'd5) ph++;
                emit(1'b1, 8'hFF);
            end
            default: evaluate(stp);
        endcase
    endfunction

    function automatic t_result controller_step(req_t r);
        nxt = '0;
        if (r.act == ACT_START && ph == PH_IDLE) begin
            is_v1 = 1'b0;
            is_hc = 1'b0;
            ph = PH_WAKE;
            cnt = '0;
            emit(1'b0, 8'hFF);
        end else if (r.act == ACT_READ && ph == PH_IDLE) begin
            begin_cmd(ST_READ, 6'd17, r.sector);
        end else if (r.act == ACT_BYTE && ph != PH_IDLE) begin
            if (r.err) finish_op(S_SPI);
            else card_byte(r.rx);
        end
        nxt.high_capacity = is_hc;
        return nxt;
    endfunction

    task automatic report(string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !in_taken) begin
                // hold the stalled request
            end else begin
                in_taken = 1'b0;
                if (gap > 0) begin
                    gap--;
                    i_valid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    req_t r;
                    int pick;
                    r = req_q.pop_front();
                    i_action <= r.act;
                    i_sector <= r.sector;
                    i_rx_byte <= r.rx;
                    i_rx_error <= r.err;
                    i_valid <= 1'b1;
                    pick = $urandom_range(0, 19);
                    if (calm || pick < 12) gap = 0;
                    else if (pick < 19) gap = $urandom_range(1, 3);
                    else gap = $urandom_range(5, 40);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result stall
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_cnt > 0) begin
                stall_cnt--;
                i_stall <= 1'b1;
            end else if (calm || $urandom_range(0, 9) < 7) begin
                i_stall <= 1'b0;
            end else begin
                stall_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                        : $urandom_range(0, 2);
                i_stall <= 1'b1;
            end
        end
    end

    // monitor: results first, then new requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (exp_q.size() == 0) report("result with nothing expected");
                else begin
                    t_result w;
                    w = exp_q.pop_front();
                    check_field("tx_valid", o_tx_valid, w.tx_valid);
                    check_field("tx_byte", o_tx_byte, w.tx_byte);
                    check_field("select_low", o_select_low, w.select_low);
                    check_field("data_valid", o_data_valid, w.data_valid);
                    check_field("data_byte", o_data_byte, w.data_byte);
                    check_field("done_res", o_done_res, w.done_res);
                    check_field("status", o_status, w.status);
                    check_field("high_capacity", o_high_capacity, w.high_capacity);
                end
            end
            if (i_valid && !o_stall) begin
                req_t r;
                r.act = t_action'(i_action);
                r.sector = i_sector;
                r.rx = i_rx_byte;
                r.err = i_rx_error;
                exp_q.push_back(controller_step(r));
                in_taken = 1'b1;
            end
        end
    end

    task automatic queue_item(t_action a, logic [31:0] s, logic [7:0] rx, logic e);
        req_t r;
        r.act = a;
        r.sector = s;
        r.rx = rx;
        r.err = e;
        req_q.push_back(r);
        queued++;
    endtask

    task automatic queue_byte(logic [7:0] rx);
        logic e;
        e = 1'b0;
        if (noise_on) begin
            // stray requests while busy, corrupted bytes, engine errors
            if ($urandom_range(0, 399) == 0)
                queue_item(t_action'($urandom_range(0, 3)), $urandom, 8'($urandom),
                           1'($urandom));
            if ($urandom_range(0, 299) == 0) rx = 8'($urandom);
            if ($urandom_range(0, 299) == 0) e = 1'b1;
        end
        queue_item(ACT_BYTE, $urandom, rx, e);
    endtask

    // one command exchange; ok is low when the response is left to time out
    task automatic card_cmd(logic [7:0] r [$], bit trail, output bit ok);
        int fills;
        fills = ($urandom_range(0, 11) == 0) ? int'(lim_resp)
                : $urandom_range(0, (lim_resp > 3) ? 3 : int'(lim_resp) - 1);
        repeat (6) queue_byte(8'($urandom));
        repeat (fills) queue_byte(8'hFF);
        ok = fills < int'(lim_resp);
        if (!ok) return;
        foreach (r[k]) queue_byte(r[k]);
        if (trail) queue_byte(8'($urandom));
    endtask

    task automatic run_init();
        bit ok, v1;
        int rounds;
        logic [7:0] ocr;
        queue_item(ACT_START, $urandom, 8'($urandom), 1'($urandom));
        repeat (WakeBytes) queue_byte(8'($urandom));
        card_cmd('{($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'h01}, 1, ok);
        if (!ok) return;
        v1 = $urandom_range(0, 2) == 0;
        if (v1) card_cmd('{8'h05}, 0, ok);
        else card_cmd('{8'h01, 8'h00, 8'h00, 8'h01,
                        ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'hAA}, 1, ok);
        if (!ok) return;
        ocr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : (8'($urandom) | 8'h3C);
        card_cmd('{8'h01, 8'($urandom), ocr, 8'($urandom), 8'($urandom)}, 1, ok);
        if (!ok) return;
        rounds = $urandom_range(0, (lim_retry > 3) ? 3 : int'(lim_retry));
        for (int k = 0; k < rounds; k++) begin
            card_cmd('{8'h01}, 1, ok);
            if (!ok) return;
            card_cmd('{8'h01}, 1, ok);
            if (!ok) return;
        end
        if (rounds >= int'(lim_retry)) return;
        card_cmd('{8'h01}, 1, ok);
        if (!ok) return;
        card_cmd('{8'h00}, 1, ok);
        if (!ok) return;
        if (!v1) begin
            case ($urandom_range(0, 4))
                0, 1: ocr = 8'($urandom) | 8'hC0;
                2, 3: ocr = (8'($urandom) & 8'h3F) | 8'h80;
                default: ocr = 8'($urandom) & 8'h7F;
            endcase
            card_cmd('{8'h00, ocr, 8'($urandom), 8'($urandom), 8'($urandom)}, 1, ok);
            if (!ok || ocr[7:6] != 2'b10) return;
        end
        card_cmd('{8'h00}, 1, ok);
    endtask

    task automatic run_read();
        bit ok, full;
        int fills, n;
        logic [31:0] s;
        logic [7:0] bad;
        case ($urandom_range(0, 3))
            0: s = 32'h0;
            1: s = 32'hFFFF_FFFF;
            default: s = $urandom;
        endcase
        queue_item(ACT_READ, s, 8'($urandom), 1'($urandom));
        card_cmd('{($urandom_range(0, 11) == 0) ? 8'h01 : 8'h00}, 0, ok);
        if (!ok) return;
        fills = (lim_token <= 16'd8) ? $urandom_range(0, int'(lim_token))
                                     : $urandom_range(0, 4);
        repeat (fills) queue_byte(8'hFF);
        if (fills >= int'(lim_token)) return;
        if ($urandom_range(0, 9) == 0) begin
            bad = 8'($urandom_range(0, 8'hFD));
            queue_byte(bad);
            return;
        end
        queue_byte(8'hFE);
        full = !full_read_done || $urandom_range(0, 7) == 0;
        n = full ? BlockBytes : $urandom_range(1, 40);
        repeat (n) queue_byte(8'($urandom));
        if (full) begin
            full_read_done = 1'b1;
            repeat (2) queue_byte(8'($urandom));
        end else begin
            queue_item(ACT_BYTE, $urandom, 8'($urandom), 1'b1);
        end
    endtask

    // let everything finish; an unfinished operation is ended by an engine error
    task automatic settle();
        forever begin
            while (req_q.size() > 0 || i_valid || exp_q.size() > 0) @(posedge i_clk);
            repeat (3) @(posedge i_clk);
            if (ph == PH_IDLE) return;
            queue_item(ACT_BYTE, $urandom, 8'($urandom), 1'b1);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RESP:  lim_resp = val[7:0];
            CFG_RETRY: lim_retry = val[7:0];
            CFG_TOKEN: lim_token = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] plan [5][3];
        plan = '{'{16'd255, 16'd255, 16'hFFFF}, '{16'd1, 16'd1, 16'd1},
                 '{16'd2, 16'd3, 16'd4}, '{16'd4, 16'd2, 16'd8},
                 '{16'd255, 16'd255, 16'hFFFF}};
        plan[3][0] = 16'($urandom_range(1, 255));
        plan[3][2] = 16'($urandom_range(1, 8));
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ignored requests, busy requests, errors, bad responses
        queue_item(ACT_NONE, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        queue_item(ACT_BYTE, 32'h0, 8'hFF, 1'b0);
        queue_item(ACT_BYTE, 32'h0, 8'h00, 1'b1);
        queue_item(ACT_START, 32'h0, 8'h00, 1'b0);
        queue_item(ACT_START, 32'h0, 8'h00, 1'b0);
        queue_item(ACT_READ, 32'hFFFF_FFFF, 8'h00, 1'b0);
        queue_item(ACT_BYTE, 32'h0, 8'hFF, 1'b0);
        queue_item(ACT_BYTE, 32'h0, 8'h00, 1'b1);
        queue_item(ACT_READ, 32'hFFFF_FFFF, 8'h00, 1'b0);
        repeat (6) queue_item(ACT_BYTE, 32'h0, 8'h00, 1'b0);
        queue_item(ACT_BYTE, 32'h0, 8'h01, 1'b0);
        queue_item(ACT_READ, 32'h0, 8'h00, 1'b0);
        repeat (6) queue_item(ACT_BYTE, 32'h0, 8'hFF, 1'b0);
        queue_item(ACT_BYTE, 32'h0, 8'h02, 1'b0);

        noise_on = 1'b1;
        for (int p = 0; p < 5; p++) begin
            settle();
            write_reg(CFG_RESP, plan[p][0]);
            write_reg(CFG_RETRY, plan[p][1]);
            write_reg(CFG_TOKEN, plan[p][2]);
            calm = (p == 2);
            while (queued < (p + 1) * 170 + 25) begin
                if ($urandom_range(0, 1) == 0) run_init();
                else run_read();
            end
        end
        settle();
        repeat (5) @(posedge i_clk);
        if (errors == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end

endmodule
